/* hw/rtl/text_console_writer_defines.svh */
// Assertion macros shared by the checkers of the text console writer.
// Every macro samples on clock and is disabled while reset is high.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication.
`define TCW_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("text_console_writer: property violated");

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("text_console_writer: property violated");

`endif

/* hw/rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// No dependencies; used by the top level and its checker.
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CELL_W  = 16;

   // Last scroll count: the final copy write lands here minus one.
   localparam int LAST_COPY = CELLS - COLUMNS;

   typedef logic [ADDR_W-1:0] addr_type;

   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [7:0]        NEWLINE     = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0720;
   localparam logic [7:0]        COLOR_RESET = 8'h07;

   localparam int         CSR_ADDR_W     = 3;
   localparam logic       REG_TEXT_COLOR = 1'b0;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [6:0] cell_x;
      logic [4:0] cell_y;
      logic [7:0] cell_color;
   } req_type;

   typedef struct packed {
      logic [4:0]        cursor_row;
      logic [6:0]        cursor_column;
      logic [CELL_W-1:0] cell_word;
      logic              scrolled;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL,
      ST_CLEAR
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/tcw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/text_console_writer.sv */
// Text console over an 80x25 store of 16-bit character cells held in one RAM.
// Put, write-cell and clear words are answered as they are taken, a cell read
// from the read state with the registered RAM data. A line advance on the last
// row scrolls: the sequencer copies every cell up one row through the single
// RAM port pair, then blanks the bottom row. A clear, and the pass right after
// reset, write blanks one cell per cycle into every cell. No input word is
// taken during these sweeps; register writes are taken at any time. Depends on
// tcw_pkg and tcw_ram.
`default_nettype none

module text_console_writer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire tcw_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output tcw_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [tcw_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic      [31:0]                         csr_prdata,
   output logic                                     csr_pready
);

   tcw_pkg::state_type state_ff, state_in;
   tcw_pkg::addr_type  cnt_ff, cnt_in;
   logic [4:0]         row_ff, row_in;
   logic [6:0]         col_ff, col_in;
   logic [7:0]         color_ff, color_in;
   logic               rd_range_ff, rd_range_in;

   logic               rsp_valid_ff, pend_valid_ff;
   tcw_pkg::rsp_type   rsp_ff, pend_ff;

   logic               res_fire;
   tcw_pkg::rsp_type   res;

   logic                      wr_en, rd_en;
   tcw_pkg::addr_type         wr_addr, rd_addr;
   logic [tcw_pkg::CELL_W-1:0] wr_data, rd_data;

   logic               req_fire, in_range, last_row, col_last;
   tcw_pkg::addr_type  pos_addr, cur_addr;
   logic               csr_write;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      color_in = color_ff;
      if (csr_write && (csr_paddr[2] == tcw_pkg::REG_TEXT_COLOR)) begin
         color_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == tcw_pkg::REG_TEXT_COLOR) begin
         csr_prdata = {24'd0, color_ff};
      end
   end

   // The skid register must be free before a word is taken.
   assign req_ready = (state_ff == tcw_pkg::ST_IDLE) && !pend_valid_ff;
   assign req_fire  = req_valid && req_ready;

   assign in_range = (int'(req_data.cell_x) < tcw_pkg::COLUMNS)
                  && (int'(req_data.cell_y) < tcw_pkg::ROWS);
   assign pos_addr = tcw_pkg::addr_type'(int'(req_data.cell_y) * tcw_pkg::COLUMNS
                                         + int'(req_data.cell_x));
   assign cur_addr = tcw_pkg::addr_type'(int'(row_ff) * tcw_pkg::COLUMNS + int'(col_ff));
   assign last_row = int'(row_ff) >= tcw_pkg::ROWS - 1;
   assign col_last = int'(col_ff) + 1 >= tcw_pkg::COLUMNS;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.mode)
                  tcw_pkg::MODE_PUT: begin
                     if (((req_data.char_code == tcw_pkg::NEWLINE) || col_last)
                         && last_row) begin
                        state_in = tcw_pkg::ST_SCROLL;
                     end
                  end
                  tcw_pkg::MODE_CLEAR: state_in = tcw_pkg::ST_CLEAR;
                  tcw_pkg::MODE_READ:  state_in = tcw_pkg::ST_READ;
                  default:             state_in = tcw_pkg::ST_IDLE;
               endcase
            end
         end
         tcw_pkg::ST_READ: state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_SCROLL: begin
            if (cnt_ff == tcw_pkg::addr_type'(tcw_pkg::LAST_COPY)) begin
               state_in = tcw_pkg::ST_FILL;
            end
         end
         tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
            if (cnt_ff == tcw_pkg::addr_type'(tcw_pkg::CELLS - 1)) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = cnt_ff;
      wr_data     = tcw_pkg::BLANK_CELL;
      rd_en       = 1'b0;
      rd_addr     = pos_addr;
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      rd_range_in = rd_range_ff;
      res_fire    = 1'b0;
      res         = '0;

      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.mode)
                  tcw_pkg::MODE_PUT: begin
                     res_fire = 1'b1;
                     if (req_data.char_code != tcw_pkg::NEWLINE) begin
                        wr_en   = 1'b1;
                        wr_addr = cur_addr;
                        wr_data = {color_ff, req_data.char_code};
                        col_in  = col_ff + 7'd1;
                     end
                     if ((req_data.char_code == tcw_pkg::NEWLINE) || col_last) begin
                        col_in = '0;
                        if (last_row) begin
                           res.scrolled = 1'b1;
                           cnt_in       = '0;
                        end else begin
                           row_in = row_ff + 5'd1;
                        end
                     end
                  end
                  tcw_pkg::MODE_CLEAR: begin
                     res_fire = 1'b1;
                     row_in   = '0;
                     col_in   = '0;
                     cnt_in   = '0;
                  end
                  tcw_pkg::MODE_WRITE: begin
                     res_fire = 1'b1;
                     wr_en    = in_range;
                     wr_addr  = pos_addr;
                     wr_data  = {req_data.cell_color, req_data.char_code};
                  end
                  default: begin
                     rd_en       = 1'b1;
                     rd_range_in = in_range;
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            res_fire = 1'b1;
            if (rd_range_ff) begin
               res.cell_word = rd_data;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            // Read one row below while the previous read is written back.
            rd_en   = cnt_ff < tcw_pkg::addr_type'(tcw_pkg::LAST_COPY);
            rd_addr = tcw_pkg::addr_type'(int'(cnt_ff) + tcw_pkg::COLUMNS);
            wr_en   = cnt_ff != '0;
            wr_addr = cnt_ff - tcw_pkg::addr_type'(1);
            wr_data = rd_data;
            if (cnt_ff != tcw_pkg::addr_type'(tcw_pkg::LAST_COPY)) begin
               cnt_in = cnt_ff + tcw_pkg::addr_type'(1);
            end
         end
         tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + tcw_pkg::addr_type'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase

      res.cursor_row    = row_in;
      res.cursor_column = col_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tcw_pkg::ST_CLEAR;
         cnt_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         color_ff    <= tcw_pkg::COLOR_RESET;
         rd_range_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         color_ff    <= color_in;
         rd_range_ff <= rd_range_in;
      end
   end

   // Output register with one skid word behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff  <= pend_valid_ff || res_fire;
         pend_valid_ff <= pend_valid_ff && res_fire;
      end else if (res_fire) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_ff  <= pend_valid_ff ? pend_ff : res;
         pend_ff <= res;
      end else if (res_fire) begin
         pend_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* hw/rtl/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_defines.svh.
`default_nettype none

`include "text_console_writer_defines.svh"

module tcw_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire tcw_pkg::rsp_type rsp_data
);

   // A word that is not taken stays on the port unchanged.
   `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // The cursor always lies on the screen.
   `TCW_ASSERT_IMP(a_cursor_range, rsp_valid,
      (int'(rsp_data.cursor_row) < tcw_pkg::ROWS)
      && (int'(rsp_data.cursor_column) < tcw_pkg::COLUMNS))

   // A scroll leaves the cursor at the start of the bottom row.
   `TCW_ASSERT_IMP(a_scroll_cursor, rsp_valid && rsp_data.scrolled,
      (rsp_data.cursor_column == '0)
      && (int'(rsp_data.cursor_row) == tcw_pkg::ROWS - 1))

   // The screen is being blanked right after reset, so no word is taken.
   `TCW_ASSERT_IMP(a_busy_after_reset, $fell(reset), !req_ready)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
